>>> design/assert_macros.svh
// assertion helpers used by the encoder design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> design/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types and constants shared by the UTF-16 to UTF-8 encoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

   // most bytes one code unit can produce (replacement plus a 3-byte char)
   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = 3;

   // replacement character U+FFFD in UTF-8
   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   // surrogate classification
   localparam logic [5:0] HIGH_TAG = 6'b110110;
   localparam logic [5:0] LOW_TAG  = 6'b110111;

   // byte run of one unit, entry 0 goes out first
   typedef logic [MAX_BYTES-1:0][7:0] byte_run_type;

   typedef struct packed {
      byte_run_type     bytes;
      logic [CNT_W-1:0] count;
      logic             hold_valid;
      logic [9:0]       hold_bits;
   } enc_result_type;

endpackage

`default_nettype wire

>>> design/u16u8_if.sv
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        final_unit;

   modport source (output valid, output code_unit, output final_unit, input ready);
   modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;

   modport source (output valid, output out_byte, output run_last, output string_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input string_done,
                   output ready);
endinterface

`default_nettype wire

>>> design/u16u8_enc.sv
// ----------------------------------------------------------------------------
// u16u8_enc
// Combinational encoder: one code unit plus the held high surrogate in,
// the byte run and the next held state out.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_enc (
   input  wire logic [15:0]               unit_i,
   input  wire logic                      final_i,
   input  wire logic                      pend_valid_i,
   input  wire logic [9:0]                pend_bits_i,
   output u16u8_pkg::enc_result_type      result_o
);

   logic                            is_high;
   logic                            is_low;
   logic                            pair;
   logic [20:0]                     cp;
   logic [2:0][7:0]                 unit_bytes;
   logic [1:0]                      unit_len;
   logic [2:0][7:0]                 own_bytes;
   logic [1:0]                      own_len;

   // surrogate class of the new unit
   assign is_high = (unit_i[15:10] == u16u8_pkg::HIGH_TAG);
   assign is_low  = (unit_i[15:10] == u16u8_pkg::LOW_TAG);
   assign pair    = pend_valid_i & is_low;

   // joined code point of a surrogate pair
   assign cp = 21'h10000 + {1'b0, pend_bits_i, unit_i[9:0]};

   // plain BMP encoding of the unit
   always_comb begin
      unit_bytes = '0;
      if (unit_i[15:7] == 9'd0) begin
         unit_bytes[0] = {1'b0, unit_i[6:0]};
         unit_len      = 2'd1;
      end else if (unit_i[15:11] == 5'd0) begin
         unit_bytes[0] = {3'b110, unit_i[10:6]};
         unit_bytes[1] = {2'b10, unit_i[5:0]};
         unit_len      = 2'd2;
      end else begin
         unit_bytes[0] = {4'b1110, unit_i[15:12]};
         unit_bytes[1] = {2'b10, unit_i[11:6]};
         unit_bytes[2] = {2'b10, unit_i[5:0]};
         unit_len      = 2'd3;
      end
   end

   // bytes the unit gives on its own (lone surrogates become replacement)
   always_comb begin
      own_bytes = '0;
      own_len   = 2'd0;
      if (is_high) begin
         if (final_i) begin
            own_bytes = {u16u8_pkg::REPL_B2, u16u8_pkg::REPL_B1, u16u8_pkg::REPL_B0};
            own_len   = 2'd3;
         end
      end else if (is_low) begin
         own_bytes = {u16u8_pkg::REPL_B2, u16u8_pkg::REPL_B1, u16u8_pkg::REPL_B0};
         own_len   = 2'd3;
      end else if (unit_i != 16'd0) begin
         own_bytes = unit_bytes;
         own_len   = unit_len;
      end
   end

   // assemble the run and the next held state
   always_comb begin
      result_o            = '0;
      result_o.hold_valid = is_high & ~final_i & ~pair;
      result_o.hold_bits  = unit_i[9:0];
      if (pair) begin
         result_o.bytes[0] = {5'b11110, cp[20:18]};
         result_o.bytes[1] = {2'b10, cp[17:12]};
         result_o.bytes[2] = {2'b10, cp[11:6]};
         result_o.bytes[3] = {2'b10, cp[5:0]};
         result_o.count    = 3'd4;
      end else if (pend_valid_i) begin
         result_o.bytes[0] = u16u8_pkg::REPL_B0;
         result_o.bytes[1] = u16u8_pkg::REPL_B1;
         result_o.bytes[2] = u16u8_pkg::REPL_B2;
         result_o.bytes[3] = own_bytes[0];
         result_o.bytes[4] = own_bytes[1];
         result_o.bytes[5] = own_bytes[2];
         result_o.count    = 3'd3 + {1'b0, own_len};
      end else begin
         result_o.bytes[0] = own_bytes[0];
         result_o.bytes[1] = own_bytes[1];
         result_o.bytes[2] = own_bytes[2];
         result_o.count    = {1'b0, own_len};
      end
   end

endmodule

`default_nettype wire

>>> design/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Streams UTF-16 code units in and UTF-8 bytes out, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req: one code unit per beat with final_unit marking the string's last unit.
//   rsp: one UTF-8 byte per beat; run_last marks the last byte of a unit's run,
//        string_done marks every byte caused by the final unit.
//   A high surrogate is held and produces its bytes with the next unit; an
//   unpaired surrogate comes out as EF BF BD. A zero unit gives no bytes.
// Path: a unit's beat loads the input register, and once the byte-run register is
//   free it takes the unit's bytes, from which the first byte is offered.
// Throughput: the byte-run register drains one byte per cycle while rsp is ready; a
//   unit gives 1 byte for ASCII and up to 6 for a replacement plus a three-byte
//   character, and the next run loads as the last byte of the current one leaves.
// Reset: clears the held surrogate and the valid and count state of both registers; no clearing pass.
// Stall: while rsp is not ready the byte run holds, the input register fills
//   and then req.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module utf16_to_utf8_encoder (
   input  wire logic      clock,
   input  wire logic      reset,
   u16u8_req_if.sink      req_bus,
   u16u8_rsp_if.source    rsp_bus
);

   // input register
   logic                                 in_valid_ff, in_valid_in;
   logic [15:0]                          in_unit_ff;
   logic                                 in_fin_ff;

   // byte-run register
   logic                                 run_valid_ff, run_valid_in;
   logic [u16u8_pkg::CNT_W-1:0]          run_count_ff, run_count_in;
   u16u8_pkg::byte_run_type              run_bytes_ff, run_bytes_in;
   logic                                 run_fin_ff, run_fin_in;

   // held high surrogate
   logic                                 pend_valid_ff, pend_valid_in;
   logic [9:0]                           pend_bits_ff, pend_bits_in;

   u16u8_pkg::enc_result_type            enc;
   logic                                 req_take;
   logic                                 rsp_pop;
   logic                                 run_free;
   logic                                 in_move;
   logic                                 run_load;

   // encoder between the registers
   u16u8_enc u_enc (
      .unit_i       (in_unit_ff),
      .final_i      (in_fin_ff),
      .pend_valid_i (pend_valid_ff),
      .pend_bits_i  (pend_bits_ff),
      .result_o     (enc)
   );

   // handshakes
   assign rsp_pop  = run_valid_ff & rsp_bus.ready;
   assign run_free = ~run_valid_ff | (rsp_bus.ready & (run_count_ff == 3'd1));
   assign in_move  = in_valid_ff & run_free;
   assign run_load = in_move & (enc.count != 3'd0);
   assign req_bus.ready = ~in_valid_ff | in_move;
   assign req_take = req_bus.valid & req_bus.ready;

   // output beat
   assign rsp_bus.valid       = run_valid_ff;
   assign rsp_bus.out_byte    = run_bytes_ff[0];
   assign rsp_bus.run_last    = (run_count_ff == 3'd1);
   assign rsp_bus.string_done = run_fin_ff;

   // next-state logic
   always_comb begin
      in_valid_in   = in_valid_ff;
      run_valid_in  = run_valid_ff;
      run_count_in  = run_count_ff;
      run_bytes_in  = run_bytes_ff;
      run_fin_in    = run_fin_ff;
      pend_valid_in = pend_valid_ff;
      pend_bits_in  = pend_bits_ff;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end

      if (run_load) begin
         run_valid_in = 1'b1;
         run_count_in = enc.count;
         run_bytes_in = enc.bytes;
         run_fin_in   = in_fin_ff;
      end else if (rsp_pop) begin
         if (run_count_ff == 3'd1) begin
            run_valid_in = 1'b0;
         end
         run_count_in = run_count_ff - 3'd1;
         run_bytes_in = run_bytes_ff >> 8;
      end

      if (in_move) begin
         pend_valid_in = enc.hold_valid;
         pend_bits_in  = enc.hold_bits;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         run_valid_ff  <= 1'b0;
         run_count_ff  <= '0;
         pend_valid_ff <= 1'b0;
         pend_bits_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         run_valid_ff  <= run_valid_in;
         run_count_ff  <= run_count_in;
         pend_valid_ff <= pend_valid_in;
         pend_bits_ff  <= pend_bits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_unit_ff <= req_bus.code_unit;
         in_fin_ff  <= req_bus.final_unit;
      end
      run_bytes_ff <= run_bytes_in;
      run_fin_ff   <= run_fin_in;
   end

   // checks
   `ASSERT_SAME(a_run_count, clock, reset, run_valid_ff,
                (run_count_ff != 3'd0) && (run_count_ff <= 3'd6))
   `ASSERT_SAME(a_load_free, clock, reset, run_load,
                !run_valid_ff || (rsp_bus.ready && run_count_ff == 3'd1))
   `ASSERT_NEXT(a_final_clears, clock, reset, in_move && in_fin_ff, !pend_valid_ff)
   `ASSERT_SAME(a_stall_full, clock, reset, !req_bus.ready, in_valid_ff && run_valid_ff)

endmodule

`default_nettype wire

>>> dv/utf16_to_utf8_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_test
// Sends code unit strings into the encoder and checks every UTF-8 byte beat
// in order against a predictor of the surrogate pairing and byte encoding.
// The sender and the receiver idle at random, and at one point the receiver
// holds off long enough to back up the input side.
// ----------------------------------------------------------------------------

module utf16_to_utf8_encoder_test;

   localparam logic [20:0] REPLACEMENT_CP = 21'h0FFFD;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam int UNITS_PER_PHASE = 150;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        final_unit;
   } code_unit_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } utf8_beat_type;

   logic clock;
   logic reset;

   u16u8_req_if req_bus ();
   u16u8_rsp_if rsp_bus ();

   utf16_to_utf8_encoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   code_unit_beat_type unit_backlog[$];
   utf8_beat_type      utf8_expected[$];

   // predictor state: held high surrogate
   logic       held_high_valid = 1'b0;
   logic [9:0] held_high_bits  = 10'd0;

   // bytes worked out for the unit being predicted
   logic [7:0] run_bytes [0:u16u8_pkg::MAX_BYTES-1];
   int         run_count;

   int req_idle_pct;
   int rsp_idle_pct;
   logic hold_request = 1'b0;
   logic hold_taken;
   int   hold_left;
   int   mismatch_count = 0;
   int   quiet_cycles;

   // clock, and known values on every input from time zero
   initial begin
      clock = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.code_unit = 16'd0;
      req_bus.final_unit = 1'b0;
      rsp_bus.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic void push_byte(input logic [7:0] b);
      run_bytes[run_count] = b;
      run_count++;
   endfunction

   // UTF-8 encoding of one code point
   function automatic void add_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         push_byte({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
         push_byte({3'b110, cp[10:6]});
         push_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         push_byte({4'b1110, cp[15:12]});
         push_byte({2'b10, cp[11:6]});
         push_byte({2'b10, cp[5:0]});
      end else begin
         push_byte({5'b11110, cp[20:18]});
         push_byte({2'b10, cp[17:12]});
         push_byte({2'b10, cp[11:6]});
         push_byte({2'b10, cp[5:0]});
      end
   endfunction

   // expected byte beats for one accepted code unit
   function automatic void predict_utf8_bytes(input logic [15:0] cu, input logic fin);
      logic          is_high;
      logic          is_low;
      logic          was_held;
      utf8_beat_type beat;
      is_high = (cu[15:10] == u16u8_pkg::HIGH_TAG);
      is_low  = (cu[15:10] == u16u8_pkg::LOW_TAG);
      was_held = held_high_valid;
      held_high_valid = 1'b0;
      run_count = 0;
      if (was_held && is_low) begin
         add_code_point(SUPPLEMENTARY_BASE + {1'b0, held_high_bits, cu[9:0]});
      end else begin
         // unpaired held high goes out as a replacement first
         if (was_held) add_code_point(REPLACEMENT_CP);
         if (is_high && !fin) begin
            held_high_valid = 1'b1;
            held_high_bits = cu[9:0];
         end else if (is_high || is_low) begin
            add_code_point(REPLACEMENT_CP);
         end else if (cu != 16'd0) begin
            add_code_point({5'd0, cu});
         end
      end
      for (int i = 0; i < run_count; i++) begin
         beat.out_byte = run_bytes[i];
         beat.run_last = (i == run_count - 1);
         beat.string_done = fin;
         utf8_expected.push_back(beat);
      end
   endfunction

   function automatic void queue_unit(input logic [15:0] cu, input logic fin);
      code_unit_beat_type unit;
      unit.code_unit = cu;
      unit.final_unit = fin;
      unit_backlog.push_back(unit);
   endfunction

   // one string: mostly well-formed content, some lone surrogates and noise
   function automatic int add_random_string();
      int slots;
      int pushed;
      int pick;
      logic last;
      slots = $urandom_range(1, 6);
      pushed = 0;
      for (int s = 0; s < slots; s++) begin
         pick = $urandom_range(99);
         last = (s == slots - 1);
         if (pick < 25) begin
            queue_unit(16'($urandom_range(1, 16'h7F)), last);
         end else if (pick < 40) begin
            queue_unit(16'($urandom_range(16'h80, 16'h7FF)), last);
         end else if (pick < 55) begin
            if ($urandom_range(1)) queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
            else queue_unit(16'($urandom_range(16'h800, 16'hD7FF)), last);
         end else if (pick < 80) begin
            queue_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0);
            queue_unit(16'hDC00 | 16'($urandom_range(0, 1023)), last);
            pushed++;
         end else if (pick < 85) begin
            queue_unit(16'hD800 | 16'($urandom_range(0, 1023)), last);
         end else if (pick < 90) begin
            queue_unit(16'hDC00 | 16'($urandom_range(0, 1023)), last);
         end else if (pick < 95) begin
            queue_unit(16'h0000, last);
         end else begin
            queue_unit(16'($urandom_range(0, 16'hFFFF)), last);
         end
         pushed++;
      end
      return pushed;
   endfunction

   // encoding boundaries and the surrogate corner cases
   function automatic void load_directed();
      queue_unit(16'h0041, 1'b0);
      queue_unit(16'h0000, 1'b0);   // zero unit, no bytes
      queue_unit(16'h007F, 1'b0);
      queue_unit(16'h0080, 1'b0);
      queue_unit(16'h07FF, 1'b0);
      queue_unit(16'h0800, 1'b0);
      queue_unit(16'hFFFF, 1'b0);
      queue_unit(16'hD800, 1'b0);   // lowest pair
      queue_unit(16'hDC00, 1'b0);
      queue_unit(16'hDBFF, 1'b0);   // highest pair
      queue_unit(16'hDFFF, 1'b0);
      queue_unit(16'hDC00, 1'b0);   // low with nothing held
      queue_unit(16'hDA12, 1'b0);   // held high, then a three-byte char
      queue_unit(16'hFFFF, 1'b0);
      queue_unit(16'hD801, 1'b0);   // held high replaced by another high
      queue_unit(16'hDBFE, 1'b0);
      queue_unit(16'hDC01, 1'b0);
      queue_unit(16'hD900, 1'b0);   // held high, then zero
      queue_unit(16'h0000, 1'b0);
      queue_unit(16'hDBFF, 1'b1);   // high as the final unit
      queue_unit(16'hD800, 1'b0);   // held high, then high as the final unit
      queue_unit(16'hDBFF, 1'b1);
      queue_unit(16'h0000, 1'b1);   // final unit with no bytes
      queue_unit(16'hDFFF, 1'b1);   // lone low as the final unit
      queue_unit(16'hDB00, 1'b0);   // pair closing the string
      queue_unit(16'hDE00, 1'b1);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_utf8_bytes(unit_backlog[0].code_unit, unit_backlog[0].final_unit);
            void'(unit_backlog.pop_front());
         end
         // an offered beat stays put until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (unit_backlog.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.code_unit <= unit_backlog[0].code_unit;
               req_bus.final_unit <= unit_backlog[0].final_unit;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      utf8_beat_type seen;
      utf8_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.out_byte = rsp_bus.out_byte;
            seen.run_last = rsp_bus.run_last;
            seen.string_done = rsp_bus.string_done;
            if (utf8_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b done %0b",
                  seen.out_byte, seen.run_last, seen.string_done));
            end else begin
               want = utf8_expected.pop_front();
               if (seen.out_byte !== want.out_byte || seen.run_last !== want.run_last ||
                   seen.string_done !== want.string_done) begin
                  report_mismatch($sformatf(
                     "byte %02h/%02h last %0b/%0b done %0b/%0b (got/expected)",
                     seen.out_byte, want.out_byte, seen.run_last, want.run_last,
                     seen.string_done, want.string_done));
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL utf16_to_utf8_encoder");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus phases: sender idles lightly, then receiver lightly, then neither
   initial begin
      int queued;
      req_idle_pct = 6;
      rsp_idle_pct = 51;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         if (phase == 0) begin
            req_idle_pct = 6;
            rsp_idle_pct = 51;
            load_directed();
         end else if (phase == 1) begin
            req_idle_pct = 51;
            rsp_idle_pct = 6;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_request = 1'b1;
         end
         queued = 0;
         while (queued < UNITS_PER_PHASE) queued += add_random_string();
         while (unit_backlog.size() > 0 || req_bus.valid || utf8_expected.size() > 0)
            @(negedge clock);
      end
      // let any stray bytes show up
      repeat (12) @(posedge clock);
      if (utf8_expected.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", utf8_expected.size()));
      if (mismatch_count == 0) begin
         $display("PASS utf16_to_utf8_encoder");
      end else begin
         $display("FAIL utf16_to_utf8_encoder");
      end
      $finish;
   end

endmodule
